/* rtl/pdcq_pkg.sv */
// Package for the paced deduplicating command queue.
// Holds sizes, request and register codes and the controller state type.
// Has no dependencies of its own.
package pdcq_pkg;

    // Number of distinct commands; also the queue capacity.
    localparam int CMD_COUNT = 32;
    localparam int PTR_W     = (CMD_COUNT > 1) ? $clog2(CMD_COUNT) : 1;
    localparam int CNT_W     = $clog2(CMD_COUNT + 1);

    // Fixed field widths.
    localparam int IDX_W     = 5;
    localparam int RATE_W    = 12;
    localparam int TICK_W    = 14;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    // ASCII '1' is the base of every command byte.
    localparam logic [BYTE_W-1:0] CMD_BASE = 8'h31;

    // Request kinds.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISABLE_IDX = 2'd1;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

endpackage

/* rtl/paced_dedup_command_queue.sv */
// A load or a non-sending tick updates the queue registers directly; a sending tick reads the head
// slot into r_rd_data (ST_READ), then registers its byte; a disable announcement is registered directly.
// Throughput: one transaction per cycle, except that a sending tick stalls requests while its slot
// is read and a held command byte stalls every request until it is taken.
// Reset (synchronous, active low) empties the queue, clears all pending marks, the tick
// counter and the enabled flag at once; the slot memory needs no clearing pass. Uses pdcq_pkg.
module paced_dedup_command_queue
    import pdcq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Request channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_req_type,
    input  logic [IDX_W-1:0]      i_cmd_index,
    input  logic                  i_control_enabled,

    // Command byte channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [BYTE_W-1:0]     o_cmd_byte,

    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data
);

    // Slot memory: command indices in ring order.
    logic [IDX_W-1:0]   r_slots [CMD_COUNT];
    logic [IDX_W-1:0]   r_rd_data;

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CMD_COUNT-1:0] r_pending, n_pending;
    logic [TICK_W-1:0]  r_tick_cnt, n_tick_cnt;
    logic               r_was_en, n_was_en;
    logic               r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]  r_out_byte, n_out_byte;
    logic [RATE_W-1:0]  r_tick_rate;
    logic [IDX_W-1:0]   r_disable_idx;

    logic               w_accept;
    logic               w_wr_en;
    logic [TICK_W-1:0]  w_period;
    logic               w_idx_ok;
    logic [PTR_W-1:0]   w_idx_sel;
    logic [PTR_W-1:0]   w_head_sel;

    // Handshakes.
    assign o_stall     = (r_state != ST_IDLE) || (r_out_valid && i_stall);
    assign w_accept    = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_cmd_byte  = r_out_byte;

    // Send compare value is three times the rate: 2*rate + rate.
    assign w_period = {1'b0, r_tick_rate, 1'b0} + {2'b00, r_tick_rate};

    assign w_idx_ok   = 32'(i_cmd_index) < CMD_COUNT;
    assign w_idx_sel  = PTR_W'(i_cmd_index);
    assign w_head_sel = PTR_W'(r_rd_data);

    // Next state and datapath updates.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_pending   = r_pending;
        n_tick_cnt  = r_tick_cnt;
        n_was_en    = r_was_en;
        n_out_valid = r_out_valid && i_stall;
        n_out_byte  = r_out_byte;
        w_wr_en     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_LOAD) begin
                        // Enqueue unless already pending or the queue is full.
                        if (w_idx_ok && !r_pending[w_idx_sel]
                            && (r_count < CNT_W'(CMD_COUNT))) begin
                            n_pending[w_idx_sel] = 1'b1;
                            w_wr_en = 1'b1;
                            n_tail  = (r_tail == PTR_W'(CMD_COUNT - 1)) ?
                                      '0 : r_tail + 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end else if (i_control_enabled) begin
                        n_was_en = 1'b1;
                        if (r_tick_cnt == w_period) begin
                            n_tick_cnt = '0;
                            // Pop the head; its slot is read this cycle.
                            if (r_count != '0) begin
                                n_head  = (r_head == PTR_W'(CMD_COUNT - 1)) ?
                                          '0 : r_head + 1'b1;
                                n_count = r_count - 1'b1;
                                n_state = ST_READ;
                            end
                        end else begin
                            n_tick_cnt = r_tick_cnt + 1'b1;
                        end
                    end else begin
                        // Disabled tick: flush everything, announce once.
                        n_pending  = '0;
                        n_count    = '0;
                        n_head     = '0;
                        n_tail     = '0;
                        n_tick_cnt = '0;
                        if (r_was_en) begin
                            n_was_en    = 1'b0;
                            n_out_valid = 1'b1;
                            n_out_byte  = CMD_BASE + BYTE_W'(r_disable_idx);
                        end
                    end
                end
            end
            ST_READ: begin
                // Head slot data has arrived: emit it and release its mark.
                n_out_valid = 1'b1;
                n_out_byte  = CMD_BASE + BYTE_W'(r_rd_data);
                if (32'(r_rd_data) < CMD_COUNT) begin
                    n_pending[w_head_sel] = 1'b0;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and queue registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_pending   <= '0;
            r_tick_cnt  <= '0;
            r_was_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_pending   <= n_pending;
            r_tick_cnt  <= n_tick_cnt;
            r_was_en    <= n_was_en;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate   <= RATE_W'(10);
            r_disable_idx <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TICK_RATE:   r_tick_rate   <= i_cfg_data[RATE_W-1:0];
                CFG_DISABLE_IDX: r_disable_idx <= i_cfg_data[IDX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Slot memory: one write port at the tail, registered read at the head.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_slots[r_tail] <= i_cmd_index;
        end
        r_rd_data <= r_slots[r_head];
    end

    // The queue never holds more than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CMD_COUNT))
        else $error("queue count exceeds capacity");

    // A memory read completes only with the output register free.
    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !r_out_valid)
        else $error("head read while output still occupied");

    // An empty queue has its pointers together.
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with split pointers");

    // A disabled tick leaves nothing queued or pending.
    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req_type == REQ_TICK) && !i_control_enabled)
        |=> ((r_count == '0) && (r_pending == '0) && (r_tick_cnt == '0)))
        else $error("disabled tick did not flush the queue");

    // In the idle state the pending mark count matches the queue occupancy.
    a_marks_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($countones(r_pending) == 32'(r_count)))
        else $error("pending marks disagree with queue count");

endmodule
